### hw/rtl/assert_macros.svh
// assertion macros used by the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SRA_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error(msg);

// property checked at every clock edge, reset included
`define SRA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/sra_pkg.sv
// shared types, codes and defaults for the sample ring window average block
`default_nettype none
package sra_pkg;

   localparam int SAMPLE_W = 16;
   localparam int TIME_W   = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   localparam int DEFAULT_STORE_DEPTH = 128;
   localparam int DEFAULT_WINDOW      = 60;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_START,
      ST_DIVIDE,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

### hw/rtl/sra_req_if.sv
// command channel interface
`default_nettype none
interface sra_req_if
   import sra_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic        [CMD_W-1:0]    cmd;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface
`default_nettype wire

### hw/rtl/sra_rsp_if.sv
// result channel interface
`default_nettype none
interface sra_rsp_if
   import sra_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic        [STATUS_W-1:0] status;
   logic signed [SAMPLE_W-1:0] average;
   logic        [TIME_W-1:0]   stamp;

   modport source (output valid, output status, output average, output stamp, input ready);
   modport sink   (input valid, input status, input average, input stamp, output ready);
endinterface
`default_nettype wire

### hw/rtl/sra_csr_if.sv
// start time register write channel interface
`default_nettype none
interface sra_csr_if
   import sra_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/sample_ring_window_average_core.sv
// top level of the sample ring window average block
//
//   channel   direction  payload                     beat taken when
//   req_if    in         cmd, sample                 valid && ready
//   rsp_if    out        status, average, stamp      valid && ready
//   csr_if    in         data (start time)           valid && ready
//
// add, clear and unused commands are handled in the idle state: one store write at most.
// a failing request goes straight to the result state; a passing one makes WINDOW
// serial store reads, drains the last read, then runs the reciprocal multiply.
// synchronous reset; no clearing pass, only entries written since a clear are read.
// a waiting result does not block adds or clears; a request may still be
// accepted and then waits in its last state until the result register frees.
`default_nettype none
module sample_ring_window_average_core
   import sra_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH,
   parameter int WINDOW      = DEFAULT_WINDOW
) (
   input  wire       clock,
   input  wire       reset,
   sra_req_if.sink   req_if,
   sra_rsp_if.source rsp_if,
   sra_csr_if.sink   csr_if
);

   localparam int PTR_W = $clog2(STORE_DEPTH);
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
   localparam int IDX_W = $clog2(WINDOW + 1);

   state_type state_ff, state_in;

   logic [PTR_W-1:0]           rp_ff, rp_in;
   logic [PTR_W-1:0]           wp_ff, wp_in;
   logic                       empty_ff, empty_in;
   logic [TIME_W-1:0]          oldest_ff, oldest_in;
   logic [TIME_W-1:0]          start_time_ff;
   logic                       rd_vld_ff;
   logic [IDX_W-1:0]           iss_cnt_ff, iss_cnt_in;
   logic signed [SUM_W-1:0]    acc_ff, acc_in;
   logic [STATUS_W-1:0]        res_status_ff, res_status_in;
   logic signed [SAMPLE_W-1:0] res_avg_ff, res_avg_in;
   logic [TIME_W-1:0]          res_stamp_ff, res_stamp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [TIME_W-1:0]          rsp_stamp_ff, rsp_stamp_in;

   logic                       req_acc;
   logic                       rsp_free;
   logic [PTR_W-1:0]           rp_inc, wp_inc, fill;
   logic                       req_short;
   logic                       mem_wr_en, mem_rd_en;
   logic signed [SAMPLE_W-1:0] mem_rd_data;
   logic                       div_start, div_done;
   logic signed [SAMPLE_W-1:0] div_quot;

   // handshakes
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // ring pointer arithmetic
   assign rp_inc    = (rp_ff == PTR_W'(STORE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign wp_inc    = (wp_ff == PTR_W'(STORE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign fill      = (wp_ff >= rp_ff) ? (wp_ff - rp_ff)
                                       : (wp_ff + PTR_W'(STORE_DEPTH) - rp_ff);
   assign req_short = (32'(fill) < 32'(WINDOW));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_if.cmd == CMD_REQUEST) begin
               state_in = (empty_ff || req_short) ? ST_RESP : ST_READ;
            end
         end
         ST_READ: begin
            if (iss_cnt_ff == IDX_W'(WINDOW - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_START;
         ST_START:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      empty_in      = empty_ff;
      oldest_in     = oldest_ff;
      iss_cnt_in    = iss_cnt_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_avg_in    = res_avg_ff;
      res_stamp_in  = res_stamp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      div_start     = 1'b0;

      // sum the sample that came back from the store
      if (rd_vld_ff) begin
         acc_in = acc_ff + SUM_W'(mem_rd_data);
      end

      // result beat leaves
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_if.cmd)
                  CMD_ADD: begin
                     mem_wr_en = 1'b1;
                     wp_in     = wp_inc;
                     empty_in  = 1'b0;
                     // full ring drops the oldest sample
                     if (wp_inc == rp_ff) begin
                        rp_in     = rp_inc;
                        oldest_in = oldest_ff + 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     rp_in     = '0;
                     wp_in     = '0;
                     empty_in  = 1'b1;
                     oldest_in = start_time_ff;
                  end
                  CMD_REQUEST: begin
                     res_avg_in   = '0;
                     res_stamp_in = '0;
                     acc_in       = '0;
                     iss_cnt_in   = '0;
                     if (empty_ff) begin
                        res_status_in = STATUS_EMPTY;
                     end else if (req_short) begin
                        res_status_in = STATUS_SHORT;
                     end else begin
                        res_status_in = STATUS_OK;
                        res_stamp_in  = oldest_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            mem_rd_en  = 1'b1;
            rp_in      = rp_inc;
            empty_in   = (rp_inc == wp_ff);
            oldest_in  = oldest_ff + 1'b1;
            iss_cnt_in = iss_cnt_ff + 1'b1;
         end
         ST_START: begin
            div_start = 1'b1;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               res_avg_in = div_quot;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_avg_in    = res_avg_ff;
               rsp_stamp_in  = res_stamp_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rp_ff         <= '0;
         wp_ff         <= '0;
         empty_ff      <= 1'b1;
         oldest_ff     <= '0;
         start_time_ff <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         empty_ff     <= empty_in;
         oldest_ff    <= oldest_in;
         rd_vld_ff    <= mem_rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            start_time_ff <= csr_if.data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      iss_cnt_ff    <= iss_cnt_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_avg_ff    <= res_avg_in;
      res_stamp_ff  <= res_stamp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_stamp_ff  <= rsp_stamp_in;
   end

   // sample store
   sra_store_mem #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (PTR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_if.sample),
      .rd_en   (mem_rd_en),
      .rd_addr (rp_ff),
      .rd_data (mem_rd_data)
   );

   // window mean
   sra_divider #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // result port
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.status  = rsp_status_ff;
   assign rsp_if.average = rsp_avg_ff;
   assign rsp_if.stamp   = rsp_stamp_ff;

endmodule
`default_nettype wire

### hw/rtl/sra_store_mem.sv
// sample store memory, one write port and one registered read port
`default_nettype none
module sra_store_mem
   import sra_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_STORE_DEPTH,
   parameter int ADDR_W = $clog2(DEFAULT_STORE_DEPTH)
) (
   input  wire                        clock,
   input  wire                        wr_en,
   input  wire  [ADDR_W-1:0]          wr_addr,
   input  wire  signed [SAMPLE_W-1:0] wr_data,
   input  wire                        rd_en,
   input  wire  [ADDR_W-1:0]          rd_addr,
   output logic signed [SAMPLE_W-1:0] rd_data
);

   logic signed [SAMPLE_W-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered, updates only while rd_en is high
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/sra_divider.sv
// signed divide by the window length: magnitude taken on start, then a registered reciprocal multiply
`default_nettype none
module sra_divider
   import sra_pkg::*;
#(
   parameter int WINDOW = DEFAULT_WINDOW,
   parameter int SUM_W  = SAMPLE_W + $clog2(DEFAULT_WINDOW)
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire  signed [SUM_W-1:0]    dividend,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] quotient
);

   // magnitude stays below 2^SUM_W, so this reciprocal is exact for all of it
   localparam int     SHIFT   = SUM_W + $clog2(WINDOW);
   localparam int     RECIP_W = SUM_W + 1;
   localparam int     PROD_W  = SUM_W + RECIP_W;
   localparam longint RECIP   = ((longint'(1) << SHIFT) / longint'(WINDOW)) + longint'(1);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SUM_W-1:0]    mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SAMPLE_W-1:0] q_mag;

   // take the magnitude on start, multiply by the reciprocal the cycle after
   always_comb begin
      busy_in = start;
      done_in = busy_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      if (start) begin
         neg_in = dividend[SUM_W-1];
         mag_in = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      end
      if (busy_ff) begin
         prod_in = {{RECIP_W{1'b0}}, mag_ff} * {{SUM_W{1'b0}}, RECIP_C};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   // quotient magnitude sits above the fraction bits of the product
   assign q_mag    = prod_ff[SHIFT +: SAMPLE_W];
   // sign restore, truncation toward zero falls out of the magnitude divide
   assign quotient = neg_ff ? (~q_mag + 1'b1) : q_mag;
   assign done     = done_ff;

endmodule
`default_nettype wire

### hw/rtl/sra_checker.sv
// port level checks for the sample ring window average block
`default_nettype none
`include "assert_macros.svh"
module sra_checker
   import sra_pkg::*;
(
   input wire                 clock,
   input wire                 reset,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input wire [STATUS_W-1:0]  rsp_status,
   input wire [SAMPLE_W-1:0]  rsp_average,
   input wire [TIME_W-1:0]    rsp_stamp
);

   // a result beat stays until taken
   `SRA_ASSERT_RUN(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result beat dropped")

   // only the three defined status codes appear
   `SRA_ASSERT_RUN(a_status_code, rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_EMPTY || rsp_status == STATUS_SHORT), "bad status code")

   // a failed request carries zero average and stamp
   `SRA_ASSERT_RUN(a_fail_zero, rsp_valid && rsp_status != STATUS_OK |-> rsp_average == '0 && rsp_stamp == '0, "failed request with payload")

   // no result beat right after reset
   `SRA_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result beat out of reset")

endmodule

bind sample_ring_window_average_core sra_checker u_sra_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_status  (rsp_if.status),
   .rsp_average (rsp_if.average),
   .rsp_stamp   (rsp_if.stamp)
);
`default_nettype wire
